[hw/rtl/vbat_pkg.sv]
`timescale 1ns / 1ps
package vbat_pkg;

    // Fixed-point sizes
    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int SIZE_BITS  = COORD_BITS - 1;
    localparam int NUM_BITS   = SIZE_BITS + FRAC_BITS;        // quotient width
    localparam int CHUNK_LO   = (NUM_BITS + 1) / 2;           // multiplier split
    localparam int CHUNK_HI   = NUM_BITS - CHUNK_LO;
    localparam int ACC_W      = NUM_BITS + COORD_BITS + 5;    // exact translation sums
    localparam int PIPE_LAT   = NUM_BITS + 7;                 // accept edge to result beat

    // Register indexes
    localparam int IDX_BITS = 3;
    localparam logic [IDX_BITS-1:0] REG_BOX_LEFT   = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_BOX_TOP    = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_BOX_WIDTH  = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_BOX_HEIGHT = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_BOX_VALID  = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_ALIGN_MODE = 3'd5;
    localparam logic [IDX_BITS-1:0] REG_SLICE_MODE = 3'd6;
    localparam logic [IDX_BITS-1:0] REG_NEAR_TOL   = 3'd7;

    // Alignment codes
    localparam logic [3:0] ALIGN_NONE = 4'd0;
    localparam logic [3:0] ALIGN_XMIN_YMIN = 4'd1;
    localparam logic [3:0] ALIGN_XMID_YMIN = 4'd2;
    localparam logic [3:0] ALIGN_XMAX_YMIN = 4'd3;
    localparam logic [3:0] ALIGN_XMIN_YMID = 4'd4;
    localparam logic [3:0] ALIGN_XMID_YMID = 4'd5;
    localparam logic [3:0] ALIGN_XMAX_YMID = 4'd6;
    localparam logic [3:0] ALIGN_XMIN_YMAX = 4'd7;
    localparam logic [3:0] ALIGN_XMID_YMAX = 4'd8;
    localparam logic [3:0] ALIGN_XMAX_YMAX = 4'd9;

    // Slack placement codes
    localparam logic [1:0] POS_ZERO = 2'd0;
    localparam logic [1:0] POS_HALF = 2'd1;
    localparam logic [1:0] POS_FULL = 2'd2;

    typedef struct packed {
        logic [COORD_BITS-1:0] port_left;
        logic [COORD_BITS-1:0] port_top;
        logic [SIZE_BITS-1:0]  port_width;
        logic [SIZE_BITS-1:0]  port_height;
        logic [COORD_BITS-1:0] reference_scale;
    } vbat_in_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] scale_horiz;
        logic [COORD_BITS-1:0] scale_vert;
        logic [COORD_BITS-1:0] shift_horiz;
        logic [COORD_BITS-1:0] shift_vert;
        logic                  saturated;
    } vbat_out_t;

    typedef struct packed {
        logic [SIZE_BITS-1:0] rem;
        logic [NUM_BITS-1:0]  numq;   // numerator bits out at top, quotient bits in at bottom
    } div_t;

    typedef struct packed {
        logic [1:0] y;
        logic [1:0] x;
    } pos_t;

    // One restoring-division step
    function automatic div_t div_step(div_t cur, logic [SIZE_BITS-1:0] d);
        logic [SIZE_BITS:0] t;
        div_t nx;
        t = {cur.rem, cur.numq[NUM_BITS-1]};
        nx.numq = {cur.numq[NUM_BITS-2:0], 1'b0};
        if (t >= {1'b0, d})
        begin
            t = t - {1'b0, d};
            nx.numq[0] = 1'b1;
        end
        nx.rem = t[SIZE_BITS-1:0];
        return nx;
    endfunction

    // Slack placement per axis from the alignment code
    function automatic pos_t align_pos(logic [3:0] mode);
        pos_t p;
        case (mode)
            ALIGN_XMIN_YMIN: p = '{y: POS_ZERO, x: POS_ZERO};
            ALIGN_XMID_YMIN: p = '{y: POS_ZERO, x: POS_HALF};
            ALIGN_XMAX_YMIN: p = '{y: POS_ZERO, x: POS_FULL};
            ALIGN_XMIN_YMID: p = '{y: POS_HALF, x: POS_ZERO};
            ALIGN_XMID_YMID: p = '{y: POS_HALF, x: POS_HALF};
            ALIGN_XMAX_YMID: p = '{y: POS_HALF, x: POS_FULL};
            ALIGN_XMIN_YMAX: p = '{y: POS_FULL, x: POS_ZERO};
            ALIGN_XMID_YMAX: p = '{y: POS_FULL, x: POS_HALF};
            ALIGN_XMAX_YMAX: p = '{y: POS_FULL, x: POS_FULL};
            default:         p = '{y: POS_ZERO, x: POS_ZERO};
        endcase
        return p;
    endfunction

endpackage

[hw/rtl/viewbox_aspect_transform_unit.sv]
`timescale 1ns / 1ps
// Channel     Signals                                  Direction  Beat
// command     start, busy, request                     in         start & !busy
// result      done, result                             out        done (one cycle)
// config      cfg_valid, cfg_ready, cfg_index, cfg_data in        cfg_valid & cfg_ready
//
// One command per cycle; between the accept edge and the result beat lie the capture register,
// the two 47-stage bit-per-stage dividers, then six stages of compare, selection, split
// multiply, and exact sum with saturation.
// busy stays low: the pipeline always advances since results cannot be held off.
// Reset clears the valid bits and restores the register defaults.
module viewbox_aspect_transform_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  vbat_pkg::vbat_in_t                 request,
    output logic                               done,
    output vbat_pkg::vbat_out_t                result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [vbat_pkg::IDX_BITS-1:0]      cfg_index,
    input  logic [vbat_pkg::COORD_BITS-1:0]    cfg_data
);

    localparam int CB  = vbat_pkg::COORD_BITS;
    localparam int FB  = vbat_pkg::FRAC_BITS;
    localparam int SB  = vbat_pkg::SIZE_BITS;
    localparam int NB  = vbat_pkg::NUM_BITS;
    localparam int CL  = vbat_pkg::CHUNK_LO;
    localparam int CH  = vbat_pkg::CHUNK_HI;
    localparam int AW  = vbat_pkg::ACC_W;
    localparam int TW  = AW - FB;

    localparam logic [TW-1:0] SH_MAX = {{(TW-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic [TW-1:0] SH_MIN = {{(TW-CB+1){1'b1}}, {(CB-1){1'b0}}};

    // Configuration registers
    logic [CB-1:0] box_left_reg, box_top_reg;
    logic [SB-1:0] box_width_reg, box_height_reg;
    logic          box_valid_reg, slice_mode_reg;
    logic [3:0]    align_mode_reg;
    logic [15:0]   near_tol_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_left_reg   <= '0;
            box_top_reg    <= '0;
            box_width_reg  <= SB'(1) << FB;
            box_height_reg <= SB'(1) << FB;
            box_valid_reg  <= 1'b0;
            align_mode_reg <= vbat_pkg::ALIGN_XMID_YMID;
            slice_mode_reg <= 1'b0;
            near_tol_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                vbat_pkg::REG_BOX_LEFT:   box_left_reg   <= cfg_data;
                vbat_pkg::REG_BOX_TOP:    box_top_reg    <= cfg_data;
                vbat_pkg::REG_BOX_WIDTH:  box_width_reg  <= cfg_data[SB-1:0];
                vbat_pkg::REG_BOX_HEIGHT: box_height_reg <= cfg_data[SB-1:0];
                vbat_pkg::REG_BOX_VALID:  box_valid_reg  <= cfg_data[0];
                vbat_pkg::REG_ALIGN_MODE: align_mode_reg <= cfg_data[3:0];
                vbat_pkg::REG_SLICE_MODE: slice_mode_reg <= cfg_data[0];
                vbat_pkg::REG_NEAR_TOL:   near_tol_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Divider pipeline: stage 0 is the captured command, stage NB holds the quotients
    logic                 dv_vld_reg  [0:NB];
    vbat_pkg::vbat_in_t   dv_item_reg [0:NB];
    vbat_pkg::div_t       dv_x_reg    [0:NB];
    vbat_pkg::div_t       dv_y_reg    [0:NB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= NB; j++)
            begin
                dv_vld_reg[j] <= 1'b0;
            end
        end
        else
        begin
            dv_vld_reg[0] <= start && !busy;
            for (int j = 0; j < NB; j++)
            begin
                dv_vld_reg[j+1] <= dv_vld_reg[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dv_item_reg[0] <= request;
        dv_x_reg[0]    <= '{rem: '0, numq: {request.port_width, {FB{1'b0}}}};
        dv_y_reg[0]    <= '{rem: '0, numq: {request.port_height, {FB{1'b0}}}};
        for (int j = 0; j < NB; j++)
        begin
            dv_item_reg[j+1] <= dv_item_reg[j];
            dv_x_reg[j+1]    <= vbat_pkg::div_step(dv_x_reg[j], box_width_reg);
            dv_y_reg[j+1]    <= vbat_pkg::div_step(dv_y_reg[j], box_height_reg);
        end
    end

    // Stage 1: near-equal test and average
    logic [NB-1:0] qx, qy, qdiff;
    logic [NB:0]   qsum;
    logic          p1_vld_reg, p1_near_reg;
    vbat_pkg::vbat_in_t p1_item_reg;
    logic [NB-1:0] p1_qx_reg, p1_qy_reg, p1_avg_reg;

    always_comb
    begin
        qx    = dv_x_reg[NB].numq;
        qy    = dv_y_reg[NB].numq;
        qdiff = (qx > qy) ? (qx - qy) : (qy - qx);
        qsum  = {1'b0, qx} + {1'b0, qy};
    end

    always_ff @(posedge clk)
    begin
        p1_item_reg <= dv_item_reg[NB];
        p1_qx_reg   <= qx;
        p1_qy_reg   <= qy;
        p1_avg_reg  <= qsum[NB:1];
        p1_near_reg <= (qdiff <= NB'(near_tol_reg));
    end

    // Stage 2: snap, meet/slice choice, placement codes
    logic [NB-1:0]  ref_ext, rdiff, s2x_next, s2y_next, uni;
    logic           xless;
    vbat_pkg::pos_t pos_next;
    logic           p2_vld_reg;
    vbat_pkg::vbat_in_t p2_item_reg;
    logic [NB-1:0]  p2_sx_reg, p2_sy_reg;
    vbat_pkg::pos_t p2_pos_reg;

    always_comb
    begin
        ref_ext  = NB'(p1_item_reg.reference_scale);
        rdiff    = (p1_avg_reg > ref_ext) ? (p1_avg_reg - ref_ext) : (ref_ext - p1_avg_reg);
        xless    = p1_qx_reg < p1_qy_reg;
        uni      = ((slice_mode_reg ? !xless : xless)) ? p1_qx_reg : p1_qy_reg;
        s2x_next = p1_qx_reg;
        s2y_next = p1_qy_reg;
        pos_next = '{y: vbat_pkg::POS_ZERO, x: vbat_pkg::POS_ZERO};
        if (p1_near_reg)
        begin
            s2x_next = (rdiff <= NB'(near_tol_reg)) ? ref_ext : p1_avg_reg;
            s2y_next = s2x_next;
        end
        else if (align_mode_reg != vbat_pkg::ALIGN_NONE)
        begin
            s2x_next = uni;
            s2y_next = uni;
            pos_next = vbat_pkg::align_pos(align_mode_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        p2_item_reg <= p1_item_reg;
        p2_sx_reg   <= s2x_next;
        p2_sy_reg   <= s2y_next;
        p2_pos_reg  <= pos_next;
    end

    // Stage 3: split partial products scale*box size and scale*|box origin|
    logic [CB-1:0] abs_left, abs_top;
    logic          p3_vld_reg;
    vbat_pkg::vbat_in_t p3_item_reg;
    logic [NB-1:0] p3_sx_reg, p3_sy_reg;
    vbat_pkg::pos_t p3_pos_reg;
    logic [CL+SB-1:0] p3_wx_lo_reg, p3_wy_lo_reg;
    logic [CH+SB-1:0] p3_wx_hi_reg, p3_wy_hi_reg;
    logic [CL+CB-1:0] p3_ox_lo_reg, p3_oy_lo_reg;
    logic [CH+CB-1:0] p3_ox_hi_reg, p3_oy_hi_reg;

    always_comb
    begin
        abs_left = box_left_reg[CB-1] ? (CB'(0) - box_left_reg) : box_left_reg;
        abs_top  = box_top_reg[CB-1]  ? (CB'(0) - box_top_reg)  : box_top_reg;
    end

    always_ff @(posedge clk)
    begin
        p3_item_reg  <= p2_item_reg;
        p3_sx_reg    <= p2_sx_reg;
        p3_sy_reg    <= p2_sy_reg;
        p3_pos_reg   <= p2_pos_reg;
        p3_wx_lo_reg <= (CL+SB)'(p2_sx_reg[CL-1:0])  * (CL+SB)'(box_width_reg);
        p3_wx_hi_reg <= (CH+SB)'(p2_sx_reg[NB-1:CL]) * (CH+SB)'(box_width_reg);
        p3_wy_lo_reg <= (CL+SB)'(p2_sy_reg[CL-1:0])  * (CL+SB)'(box_height_reg);
        p3_wy_hi_reg <= (CH+SB)'(p2_sy_reg[NB-1:CL]) * (CH+SB)'(box_height_reg);
        p3_ox_lo_reg <= (CL+CB)'(p2_sx_reg[CL-1:0])  * (CL+CB)'(abs_left);
        p3_ox_hi_reg <= (CH+CB)'(p2_sx_reg[NB-1:CL]) * (CH+CB)'(abs_left);
        p3_oy_lo_reg <= (CL+CB)'(p2_sy_reg[CL-1:0])  * (CL+CB)'(abs_top);
        p3_oy_hi_reg <= (CH+CB)'(p2_sy_reg[NB-1:CL]) * (CH+CB)'(abs_top);
    end

    // Stage 4: slack = port<<2F - scale*size, signed origin product
    logic [AW-1:0] ubx, uby, pmx, pmy;
    logic          p4_vld_reg;
    vbat_pkg::vbat_in_t p4_item_reg;
    logic [NB-1:0] p4_sx_reg, p4_sy_reg;
    vbat_pkg::pos_t p4_pos_reg;
    logic [AW-1:0] p4_slx_reg, p4_sly_reg, p4_px_reg, p4_py_reg;

    always_comb
    begin
        ubx = (AW'(p3_wx_hi_reg) << CL) + AW'(p3_wx_lo_reg);
        uby = (AW'(p3_wy_hi_reg) << CL) + AW'(p3_wy_lo_reg);
        pmx = (AW'(p3_ox_hi_reg) << CL) + AW'(p3_ox_lo_reg);
        pmy = (AW'(p3_oy_hi_reg) << CL) + AW'(p3_oy_lo_reg);
    end

    always_ff @(posedge clk)
    begin
        p4_item_reg <= p3_item_reg;
        p4_sx_reg   <= p3_sx_reg;
        p4_sy_reg   <= p3_sy_reg;
        p4_pos_reg  <= p3_pos_reg;
        p4_slx_reg  <= (AW'(p3_item_reg.port_width) << (2*FB)) - ubx;
        p4_sly_reg  <= (AW'(p3_item_reg.port_height) << (2*FB)) - uby;
        p4_px_reg   <= box_left_reg[CB-1] ? (AW'(0) - pmx) : pmx;
        p4_py_reg   <= box_top_reg[CB-1]  ? (AW'(0) - pmy) : pmy;
    end

    // Stage 5: exact translation in Q(2F), floored to Q(F)
    function automatic logic [AW-1:0] pick_off(logic [1:0] pos, logic [AW-1:0] slack);
        logic [AW-1:0] o;
        case (pos)
            vbat_pkg::POS_HALF: o = {slack[AW-1], slack[AW-1:1]};
            vbat_pkg::POS_FULL: o = slack;
            default:            o = '0;
        endcase
        return o;
    endfunction

    logic [AW-1:0] tx, ty;
    logic          p5_vld_reg;
    vbat_pkg::vbat_in_t p5_item_reg;
    logic [NB-1:0] p5_sx_reg, p5_sy_reg;
    logic [TW-1:0] p5_tx_reg, p5_ty_reg;

    always_comb
    begin
        tx = {{(AW-CB-2*FB){p4_item_reg.port_left[CB-1]}}, p4_item_reg.port_left, {(2*FB){1'b0}}}
             + pick_off(p4_pos_reg.x, p4_slx_reg) - p4_px_reg;
        ty = {{(AW-CB-2*FB){p4_item_reg.port_top[CB-1]}}, p4_item_reg.port_top, {(2*FB){1'b0}}}
             + pick_off(p4_pos_reg.y, p4_sly_reg) - p4_py_reg;
    end

    always_ff @(posedge clk)
    begin
        p5_item_reg <= p4_item_reg;
        p5_sx_reg   <= p4_sx_reg;
        p5_sy_reg   <= p4_sy_reg;
        p5_tx_reg   <= tx[AW-1:FB];
        p5_ty_reg   <= ty[AW-1:FB];
    end

    // Stage 6: saturation and result register
    logic                box_ok;
    logic                sat_sx, sat_sy, hi_tx, lo_tx, hi_ty, lo_ty;
    vbat_pkg::vbat_out_t result_next, result_reg;
    logic                done_reg;

    always_comb
    begin
        box_ok = box_valid_reg && (box_width_reg != '0) && (box_height_reg != '0);
        sat_sx = (p5_sx_reg[NB-1:CB] != '0);
        sat_sy = (p5_sy_reg[NB-1:CB] != '0);
        hi_tx  = $signed(p5_tx_reg) > $signed(SH_MAX);
        lo_tx  = $signed(p5_tx_reg) < $signed(SH_MIN);
        hi_ty  = $signed(p5_ty_reg) > $signed(SH_MAX);
        lo_ty  = $signed(p5_ty_reg) < $signed(SH_MIN);
        if (box_ok)
        begin
            result_next.scale_horiz = sat_sx ? {CB{1'b1}} : p5_sx_reg[CB-1:0];
            result_next.scale_vert  = sat_sy ? {CB{1'b1}} : p5_sy_reg[CB-1:0];
            result_next.shift_horiz = hi_tx ? SH_MAX[CB-1:0]
                                    : (lo_tx ? SH_MIN[CB-1:0] : p5_tx_reg[CB-1:0]);
            result_next.shift_vert  = hi_ty ? SH_MAX[CB-1:0]
                                    : (lo_ty ? SH_MIN[CB-1:0] : p5_ty_reg[CB-1:0]);
            result_next.saturated   = sat_sx || sat_sy || hi_tx || lo_tx || hi_ty || lo_ty;
        end
        else
        begin
            result_next.scale_horiz = CB'(1) << FB;
            result_next.scale_vert  = CB'(1) << FB;
            result_next.shift_horiz = p5_item_reg.port_left;
            result_next.shift_vert  = p5_item_reg.port_top;
            result_next.saturated   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // Valid bits of the back stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            p4_vld_reg <= 1'b0;
            p5_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            p1_vld_reg <= dv_vld_reg[NB];
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
            p4_vld_reg <= p3_vld_reg;
            p5_vld_reg <= p4_vld_reg;
            done_reg   <= p5_vld_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Checks
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(vbat_pkg::PIPE_LAT) done)
        else $error("command did not produce a result at the pipeline latency");

    a_no_box: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !box_valid_reg) |-> (!result.saturated && result.scale_horiz == (CB'(1) << FB)))
        else $error("no viewBox but result is not unit scale");

    a_uniform: assert property (@(posedge clk) disable iff (!rst_n)
        (done && box_ok && align_mode_reg != vbat_pkg::ALIGN_NONE)
            |-> (result.scale_horiz == result.scale_vert))
        else $error("aligned result has unequal scales");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(p5_vld_reg))
        else $error("result strobe without an item in the last stage");

endmodule

[tb/vbat_checker.sv]
`timescale 1ns / 1ps
module vbat_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  vbat_pkg::vbat_in_t              request,
    input  logic                            done,
    input  vbat_pkg::vbat_out_t             result,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [vbat_pkg::IDX_BITS-1:0]   cfg_index,
    input  logic [vbat_pkg::COORD_BITS-1:0] cfg_data,
    output int                              fail_count,
    output int                              pending_count
);
    import vbat_pkg::*;

    // Shadow copy of the configuration registers
    logic [31:0] box_left, box_top;
    logic [30:0] box_width, box_height;
    logic        box_valid, slice_mode;
    logic [3:0]  align_mode;
    logic [15:0] near_tol;

    vbat_out_t expected_transforms[$];

    function automatic logic signed [127:0] abs_diff(logic signed [127:0] a,
                                                      logic signed [127:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Offset of the box within the viewport in Q32: none, half or all of the slack
    function automatic logic signed [127:0] slack_offset(logic signed [127:0] port,
                                                          logic signed [127:0] box,
                                                          logic signed [127:0] scale,
                                                          int pos);
        logic signed [127:0] slack;
        slack = (port <<< 32) - scale * box;
        if (pos == 0)
            return 0;
        if (pos == 1)
            return slack >>> 1;
        return slack;
    endfunction

    // Exact translation, floored to Q16, clipped to signed 32 bits; MSB flags the clip
    function automatic logic [32:0] translation(logic signed [31:0] origin,
                                                logic signed [127:0] offset,
                                                logic signed [127:0] scale,
                                                logic signed [31:0] box_origin);
        logic signed [127:0] org, bo, t;
        org = origin;
        bo = box_origin;
        t = ((org <<< 32) + offset - scale * bo) >>> 16;
        if (t > 128'sd2147483647)
            return {1'b1, 32'h7fff_ffff};
        if (t < -128'sd2147483648)
            return {1'b1, 32'h8000_0000};
        return {1'b0, t[31:0]};
    endfunction

    function automatic vbat_out_t predict_transform(vbat_in_t req);
        logic signed [127:0] sx, sy, avg, ox, oy, bw, bh, pw, ph, ref_scale, tol;
        logic [32:0]         tx, ty;
        int                  k;
        vbat_out_t           r;
        bw = box_width;
        bh = box_height;
        pw = req.port_width;
        ph = req.port_height;
        ref_scale = req.reference_scale;
        tol = near_tol;
        ox = 0;
        oy = 0;
        // No viewBox: identity scale at the viewport origin
        if (!box_valid || bw == 0 || bh == 0)
        begin
            r.scale_horiz = 32'h0001_0000;
            r.scale_vert  = 32'h0001_0000;
            r.shift_horiz = req.port_left;
            r.shift_vert  = req.port_top;
            r.saturated   = 1'b0;
            return r;
        end
        sx = (pw <<< 16) / bw;
        sy = (ph <<< 16) / bh;
        if (abs_diff(sx, sy) <= tol)
        begin
            // near-uniform: average, snapped to the reference when close
            avg = (sx + sy) >>> 1;
            if (abs_diff(avg, ref_scale) <= tol)
                avg = ref_scale;
            sx = avg;
            sy = avg;
        end
        else if (align_mode != ALIGN_NONE)
        begin
            if (slice_mode)
                avg = (sx < sy) ? sy : sx;
            else
                avg = (sx < sy) ? sx : sy;
            sx = avg;
            sy = avg;
            if (align_mode <= ALIGN_XMAX_YMAX)
            begin
                k = int'(align_mode) - 1;
                ox = slack_offset(pw, bw, avg, k % 3);
                oy = slack_offset(ph, bh, avg, k / 3);
            end
        end
        tx = translation(req.port_left, ox, sx, box_left);
        ty = translation(req.port_top, oy, sy, box_top);
        r.shift_horiz = tx[31:0];
        r.shift_vert  = ty[31:0];
        r.saturated   = tx[32] | ty[32];
        r.scale_horiz = (sx > 128'sh0_ffff_ffff) ? 32'hffff_ffff : sx[31:0];
        r.scale_vert  = (sy > 128'sh0_ffff_ffff) ? 32'hffff_ffff : sy[31:0];
        r.saturated   = r.saturated | (sx > 128'sh0_ffff_ffff) | (sy > 128'sh0_ffff_ffff);
        return r;
    endfunction

    // Track config beats, predict on command beats, compare on result beats
    always @(posedge clk or negedge rst_n)
    begin
        vbat_out_t want;
        if (!rst_n)
        begin
            box_left   <= '0;
            box_top    <= '0;
            box_width  <= 31'h0001_0000;
            box_height <= 31'h0001_0000;
            box_valid  <= 1'b0;
            align_mode <= ALIGN_XMID_YMID;
            slice_mode <= 1'b0;
            near_tol   <= '0;
            fail_count <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BOX_LEFT:   box_left   <= cfg_data;
                    REG_BOX_TOP:    box_top    <= cfg_data;
                    REG_BOX_WIDTH:  box_width  <= cfg_data[30:0];
                    REG_BOX_HEIGHT: box_height <= cfg_data[30:0];
                    REG_BOX_VALID:  box_valid  <= cfg_data[0];
                    REG_ALIGN_MODE: align_mode <= cfg_data[3:0];
                    REG_SLICE_MODE: slice_mode <= cfg_data[0];
                    REG_NEAR_TOL:   near_tol   <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                expected_transforms.push_back(predict_transform(request));
            if (done)
            begin
                if (expected_transforms.size() == 0)
                begin
                    $error("result beat with no command outstanding");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_transforms.pop_front();
                    if (want != result)
                    begin
                        fail_count <= fail_count + 1;
                        if (want.scale_horiz != result.scale_horiz)
                            $error("scale_horiz: expected %h got %h",
                                   want.scale_horiz, result.scale_horiz);
                        if (want.scale_vert != result.scale_vert)
                            $error("scale_vert: expected %h got %h",
                                   want.scale_vert, result.scale_vert);
                        if (want.shift_horiz != result.shift_horiz)
                            $error("shift_horiz: expected %h got %h",
                                   want.shift_horiz, result.shift_horiz);
                        if (want.shift_vert != result.shift_vert)
                            $error("shift_vert: expected %h got %h",
                                   want.shift_vert, result.shift_vert);
                        if (want.saturated !== result.saturated)
                            $error("saturated: expected %b got %b",
                                   want.saturated, result.saturated);
                    end
                end
            end
            pending_count <= expected_transforms.size();
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import vbat_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    vbat_in_t              request = '0;
    logic                  done;
    vbat_out_t             result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [IDX_BITS-1:0]   cfg_index = '0;
    logic [COORD_BITS-1:0] cfg_data = '0;
    int                    fail_count, pending_count;
    int                    cycle_count = 0;

    // Current box size, used to aim viewports at near-uniform scales
    longint unsigned       cur_width = 65536, cur_height = 65536;
    int                    gap_pct = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    viewbox_aspect_transform_unit dut (.*);

    vbat_checker u_checker (.*);

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Register write; only called with the pipeline drained
    task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [31:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        if (idx == REG_BOX_WIDTH)
            cur_width = val[30:0];
        if (idx == REG_BOX_HEIGHT)
            cur_height = val[30:0];
    endtask

    // One command beat, then a random gap; start stays high when no gap follows
    task automatic send_viewport(vbat_in_t req);
        start   = 1'b1;
        request = req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        if ($urandom_range(99) < gap_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    task automatic drain();
        start = 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
    endtask

    function automatic logic [31:0] wide_rand();
        return $urandom >> $urandom_range(31);
    endfunction

    function automatic logic [30:0] size_rand();
        case ($urandom_range(7))
            0: return 31'h7fff_ffff;
            1: return 31'd1;
            2: return 31'h0001_0000;
            default: return wide_rand();
        endcase
    endfunction

    function automatic vbat_in_t gen_viewport();
        vbat_in_t        v;
        longint unsigned s, w, h;
        v.port_left = ($urandom_range(3) == 0) ? $urandom : wide_rand();
        v.port_top  = ($urandom_range(3) == 0) ? $urandom : wide_rand();
        if ($urandom_range(1))
            v.port_left = -v.port_left;
        if ($urandom_range(1))
            v.port_top = -v.port_top;
        v.reference_scale = $urandom;
        if ($urandom_range(9) < 5)
        begin
            // sizes that give nearly equal scales on both axes
            s = $urandom_range(1, 1 << 20);
            w = ((cur_width * s) >> 16) + $urandom_range(0, 3);
            h = ((cur_height * s) >> 16) + $urandom_range(0, 3);
            v.port_width  = (w > 64'h7fff_ffff) ? 31'h7fff_ffff : w[30:0];
            v.port_height = (h > 64'h7fff_ffff) ? 31'h7fff_ffff : h[30:0];
            if ($urandom_range(1))
                v.reference_scale = 32'(s) + $urandom_range(0, 8) - 4;
        end
        else
        begin
            v.port_width  = ($urandom_range(9) == 0) ? 31'd0 : size_rand();
            v.port_height = ($urandom_range(9) == 0) ? 31'd0 : size_rand();
        end
        return v;
    endfunction

    task automatic random_setup();
        write_reg(REG_BOX_LEFT, ($urandom_range(4) == 0) ? $urandom : wide_rand());
        write_reg(REG_BOX_TOP, ($urandom_range(4) == 0) ? -wide_rand() : wide_rand());
        write_reg(REG_BOX_WIDTH, ($urandom_range(9) == 0) ? $urandom : {1'b0, size_rand()});
        write_reg(REG_BOX_HEIGHT, {1'($urandom_range(1)), size_rand()});
        write_reg(REG_BOX_VALID, ($urandom_range(7) == 0) ? 32'd0 : 32'd1);
        write_reg(REG_ALIGN_MODE, $urandom_range(15));
        write_reg(REG_SLICE_MODE, $urandom_range(1));
        case ($urandom_range(3))
            0: write_reg(REG_NEAR_TOL, 32'd0);
            1: write_reg(REG_NEAR_TOL, 32'h0000_ffff);
            default: write_reg(REG_NEAR_TOL, $urandom_range(0, 64));
        endcase
    endtask

    initial
    begin
        vbat_in_t v;
        int       idle_pattern [4] = '{0, 56, 56, 22};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // No viewBox after reset: extremes of the viewport fields
        v = '{port_left: 32'h8000_0000, port_top: 32'h7fff_ffff,
              port_width: 31'h7fff_ffff, port_height: 31'd0, reference_scale: '1};
        send_viewport(v);
        v = '{port_left: 32'h7fff_ffff, port_top: 32'h8000_0000,
              port_width: 31'd0, port_height: 31'h7fff_ffff, reference_scale: '0};
        send_viewport(v);
        drain();

        // Extreme box, every alignment code, meet for even codes and slice for odd ones
        write_reg(REG_BOX_LEFT, 32'h8000_0000);
        write_reg(REG_BOX_TOP, 32'h7fff_ffff);
        write_reg(REG_BOX_WIDTH, 32'd1);
        write_reg(REG_BOX_HEIGHT, 32'h7fff_ffff);
        write_reg(REG_BOX_VALID, 32'd1);
        write_reg(REG_NEAR_TOL, 32'h0000_ffff);
        for (int a = 0; a < 16; a++)
        begin
            write_reg(REG_ALIGN_MODE, a);
            write_reg(REG_SLICE_MODE, a % 2);
            send_viewport(gen_viewport());
            drain();
        end

        // Zero box size counts as no viewBox; nearly equal scales snap to the reference
        write_reg(REG_BOX_WIDTH, 32'd0);
        send_viewport(gen_viewport());
        drain();
        write_reg(REG_BOX_WIDTH, 32'h0001_0000);
        write_reg(REG_BOX_HEIGHT, 32'h0001_0000);
        write_reg(REG_NEAR_TOL, 32'd4);
        v = '{port_left: 32'd0, port_top: 32'd0, port_width: 31'h0002_0000,
              port_height: 31'h0002_0002, reference_scale: 32'h0002_0003};
        send_viewport(v);
        drain();

        // Random phases, cycling through the sender gap patterns
        for (int ph = 0; ph < 16; ph++)
        begin
            gap_pct = idle_pattern[ph % 4];
            random_setup();
            for (int n = 0; n < 25; n++)
                send_viewport(gen_viewport());
            drain();
        end

        repeat (60) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
